// File: rtl/assert_macros.svh
// Assertion macros shared by the checker files of the tag search block.
// Needs nothing else; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion that is switched off while the reset is high.
`define TLVTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion that is checked at every edge, reset included.
`define TLVTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/tlvts_pkg.sv
// Package of the BER-TLV path and tag search: types, codes and defaults.
// Used by every module of the block; depends on nothing.
package tlvts_pkg;

  localparam int MAX_PATH_DEPTH_DEF = 3;
  localparam int LENGTH_BITS_DEF    = 24;
  localparam int CFG_IDX_W          = 3;
  localparam int CFG_DATA_W         = 24;
  localparam int VALUE_LEN_W        = 24;

  localparam logic [4:0] TAG_MULTI_MASK = 5'h1F;
  localparam logic [7:0] LEN_LONG_1     = 8'h81;
  localparam logic [7:0] LEN_LONG_2     = 8'h82;
  localparam logic [7:0] LEN_LONG_3     = 8'h83;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BUFFER_SIZE    = 3'd0,
    CFG_PATH_DEPTH     = 3'd1,
    CFG_PATH_TAG_A     = 3'd2,
    CFG_PATH_TAG_B     = 3'd3,
    CFG_PATH_TAG_C     = 3'd4,
    CFG_TARGET_TAG     = 3'd5,
    CFG_TARGET_TAG_LEN = 3'd6
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_VALUE = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2
  } status_t;

  typedef enum logic [7:0] {
    PH_START  = 8'b0000_0001,
    PH_TAG1   = 8'b0000_0010,
    PH_TAG2   = 8'b0000_0100,
    PH_LEN0   = 8'b0000_1000,
    PH_LENX   = 8'b0001_0000,
    PH_SKIP   = 8'b0010_0000,
    PH_STREAM = 8'b0100_0000,
    PH_DONE   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    logic [23:0] buffer_size;
    logic [1:0]  path_depth;
    logic [7:0]  path_tag_a;
    logic [7:0]  path_tag_b;
    logic [7:0]  path_tag_c;
    logic [15:0] target_tag;
    logic [1:0]  target_tag_len;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    status_t                status;
    logic [7:0]             value_byte;
    logic [VALUE_LEN_W-1:0] value_length;
    logic                   last;
  } res_t;

endpackage

// File: rtl/tlvts_if.sv
// Valid/ready channel interfaces for request bytes and search results.
// Standalone; widths follow the fixed field widths of the block.
interface tlvts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       start_of_buffer;

  modport source (output valid, data_byte, start_of_buffer, input ready);
  modport sink (input valid, data_byte, start_of_buffer, output ready);
endinterface

interface tlvts_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  value_byte;
  logic [23:0] value_length;
  logic        last;

  modport source (output valid, status, value_byte, value_length, last, input ready);
  modport sink (input valid, status, value_byte, value_length, last, output ready);
endinterface

// File: rtl/tlvts_cfg_regs.sv
// Configuration register file of the tag search, written through a plain port.
// Depends on tlvts_pkg for the register indexes and the cfg_t bundle.
module tlvts_cfg_regs (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 wr_en,
  input  logic [tlvts_pkg::CFG_IDX_W-1:0]      index,
  input  logic [tlvts_pkg::CFG_DATA_W-1:0]     data,
  output tlvts_pkg::cfg_t                      cfg
);
  import tlvts_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{buffer_size:    24'd1,
               path_depth:     2'd0,
               path_tag_a:     8'h00,
               path_tag_b:     8'h00,
               path_tag_c:     8'h00,
               target_tag:     16'h0000,
               target_tag_len: 2'd1};
    end else if (wr_en) begin
      unique case (cfg_idx_t'(index))
        CFG_BUFFER_SIZE:    cfg.buffer_size    <= data[23:0];
        CFG_PATH_DEPTH:     cfg.path_depth     <= data[1:0];
        CFG_PATH_TAG_A:     cfg.path_tag_a     <= data[7:0];
        CFG_PATH_TAG_B:     cfg.path_tag_b     <= data[7:0];
        CFG_PATH_TAG_C:     cfg.path_tag_c     <= data[7:0];
        CFG_TARGET_TAG:     cfg.target_tag     <= data[15:0];
        CFG_TARGET_TAG_LEN: cfg.target_tag_len <= data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tlvts_parser.sv
// Input register and per-byte TLV parse step of the tag search.
// Depends on tlvts_pkg; feeds at most one result per parsed byte to the output stage.
module tlvts_parser #(
  parameter int MAX_PATH_DEPTH = tlvts_pkg::MAX_PATH_DEPTH_DEF,
  parameter int LENGTH_BITS    = tlvts_pkg::LENGTH_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  tlvts_pkg::cfg_t cfg,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_sob,
  input  logic            out_room,
  output tlvts_pkg::res_t res
);
  import tlvts_pkg::*;

  localparam int LVL_W = (MAX_PATH_DEPTH > 0) ? $clog2(MAX_PATH_DEPTH + 1) : 1;

  logic                   q_valid;
  logic [7:0]             q_byte;
  logic                   q_sob;
  logic                   go;

  phase_t                 phase, phase_next;
  logic [15:0]            hdr, hdr_next;
  logic                   two_byte, two_byte_next;
  logic [1:0]             lbl, lbl_next;
  logic [LENGTH_BITS-1:0] rvl, rvl_next;
  logic [LENGTH_BITS-1:0] vbl, vbl_next;
  logic [LVL_W-1:0]       level, level_next;
  logic [LENGTH_BITS-1:0] scope      [0:MAX_PATH_DEPTH];
  logic [LENGTH_BITS-1:0] scope_next [0:MAX_PATH_DEPTH];

  assign go       = q_valid && out_room;
  assign in_ready = !q_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      q_byte <= in_byte;
      q_sob  <= in_sob;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_START;
      level <= '0;
    end else if (go) begin
      phase <= phase_next;
      level <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      hdr      <= hdr_next;
      two_byte <= two_byte_next;
      lbl      <= lbl_next;
      rvl      <= rvl_next;
      vbl      <= vbl_next;
      scope    <= scope_next;
    end
  end

  always_comb begin
    phase_t                 ph_e;
    logic [LVL_W-1:0]       lvl_e;
    logic [LVL_W-1:0]       lvl_p1;
    logic [15:0]            hdr_e;
    logic                   two_e;
    logic [1:0]             lbl_e;
    logic [LENGTH_BITS-1:0] rvl_e;
    logic [LENGTH_BITS-1:0] vbl_e;
    logic [LENGTH_BITS-1:0] s_e;
    logic [LENGTH_BITS-1:0] rvl_hd;
    logic [LENGTH_BITS-1:0] s_rest;
    logic [LENGTH_BITS+7:0] rvl_cat;
    logic                   start;
    logic                   fail;
    logic                   hd;
    logic                   in_path;
    logic                   two_target;
    logic                   hit_tmpl;
    logic                   hit_tgt;
    logic [7:0]             tmpl;
    int                     dnow;

    start = q_sob || (phase == PH_START);
    ph_e  = phase;
    lvl_e = level;
    hdr_e = hdr;
    two_e = two_byte;
    lbl_e = lbl;
    rvl_e = rvl;
    vbl_e = vbl;
    s_e   = scope[level];
    if (start) begin
      ph_e  = PH_TAG1;
      lvl_e = '0;
      hdr_e = '0;
      two_e = 1'b0;
      lbl_e = '0;
      rvl_e = '0;
      vbl_e = '0;
      s_e   = LENGTH_BITS'(cfg.buffer_size);
    end

    phase_next    = ph_e;
    level_next    = lvl_e;
    hdr_next      = hdr_e;
    two_byte_next = two_e;
    lbl_next      = lbl_e;
    rvl_next      = rvl_e;
    vbl_next      = vbl_e;
    scope_next    = scope;

    lvl_p1  = lvl_e + 1'b1;
    rvl_cat = {rvl_e, q_byte};
    rvl_hd  = rvl_e;
    s_rest  = s_e + ~rvl_hd;
    fail    = 1'b0;
    hd      = 1'b0;

    dnow    = (int'(cfg.path_depth) > MAX_PATH_DEPTH) ? MAX_PATH_DEPTH
                                                      : int'(cfg.path_depth);
    in_path = int'(lvl_e) < dnow;
    if (int'(lvl_e) == 0) begin
      tmpl = cfg.path_tag_a;
    end else if (int'(lvl_e) == 1) begin
      tmpl = cfg.path_tag_b;
    end else if (int'(lvl_e) == 2) begin
      tmpl = cfg.path_tag_c;
    end else begin
      tmpl = 8'h00;
    end
    two_target = cfg.target_tag_len[1];
    hit_tmpl   = !two_e && (hdr_e[15:8] == tmpl);
    hit_tgt    = (two_e == two_target) &&
                 (two_target ? (hdr_e == cfg.target_tag)
                             : (hdr_e[15:8] == cfg.target_tag[15:8]));

    res              = '0;
    res.status       = ST_VALUE;

    if (ph_e == PH_DONE) begin
      phase_next = PH_DONE;
    end else if (s_e == '0) begin
      fail = 1'b1;
    end else begin
      scope_next[lvl_e] = s_e - 1'b1;
      unique case (ph_e)
        PH_TAG1: begin
          hdr_next      = {q_byte, 8'h00};
          two_byte_next = (q_byte[4:0] == TAG_MULTI_MASK);
          if (s_e <= (two_byte_next ? LENGTH_BITS'(2) : LENGTH_BITS'(1))) begin
            fail = 1'b1;
          end else begin
            phase_next = two_byte_next ? PH_TAG2 : PH_LEN0;
          end
        end
        PH_TAG2: begin
          hdr_next[7:0] = q_byte;
          if (s_e <= LENGTH_BITS'(1)) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_LEN0;
          end
        end
        PH_LEN0: begin
          if (!q_byte[7]) begin
            rvl_hd = LENGTH_BITS'(q_byte);
            hd     = 1'b1;
          end else if (q_byte == LEN_LONG_1 || q_byte == LEN_LONG_2 ||
                       q_byte == LEN_LONG_3) begin
            lbl_next = q_byte[1:0];
            rvl_next = '0;
            if (s_e <= LENGTH_BITS'(q_byte[1:0])) begin
              fail = 1'b1;
            end else begin
              phase_next = PH_LENX;
            end
          end else begin
            fail = 1'b1;
          end
        end
        PH_LENX: begin
          rvl_hd   = rvl_cat[LENGTH_BITS-1:0];
          rvl_next = rvl_hd;
          lbl_next = lbl_e - 2'd1;
          hd       = (lbl_e == 2'd1);
        end
        PH_SKIP: begin
          vbl_next = vbl_e - 1'b1;
          if (vbl_e == LENGTH_BITS'(1)) begin
            if (s_e == LENGTH_BITS'(1)) begin
              fail = 1'b1;
            end else begin
              phase_next = PH_TAG1;
            end
          end
        end
        PH_STREAM: begin
          vbl_next         = vbl_e - 1'b1;
          res.valid        = 1'b1;
          res.value_byte   = q_byte;
          res.value_length = VALUE_LEN_W'(rvl_e);
          if (vbl_e == LENGTH_BITS'(1)) begin
            res.last   = 1'b1;
            phase_next = PH_DONE;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase

      if (hd) begin
        rvl_next = rvl_hd;
        s_rest   = s_e + ~rvl_hd;
        if (rvl_hd >= s_e) begin
          fail = 1'b1;
        end else if (in_path && hit_tmpl) begin
          if (rvl_hd == '0) begin
            fail = 1'b1;
          end else begin
            scope_next[lvl_e]  = s_rest;
            scope_next[lvl_p1] = rvl_hd;
            level_next         = lvl_p1;
            phase_next         = PH_TAG1;
          end
        end else if (!in_path && hit_tgt) begin
          if (rvl_hd == '0) begin
            res.valid  = 1'b1;
            res.status = ST_EMPTY;
            res.last   = 1'b1;
            phase_next = PH_DONE;
          end else begin
            vbl_next   = rvl_hd;
            phase_next = PH_STREAM;
          end
        end else if (rvl_hd == '0) begin
          if (s_e == LENGTH_BITS'(1)) begin
            fail = 1'b1;
          end else begin
            phase_next = PH_TAG1;
          end
        end else begin
          vbl_next   = rvl_hd;
          phase_next = PH_SKIP;
        end
      end
    end

    if (fail) begin
      phase_next       = PH_DONE;
      res.valid        = 1'b1;
      res.status       = ST_ERROR;
      res.value_byte   = 8'h00;
      res.value_length = '0;
      res.last         = 1'b1;
    end
    res.valid = res.valid && go;
  end

endmodule

// File: rtl/tlvts_out_stage.sv
// Result register of the tag search, holding one result until it is taken.
// Depends on tlvts_pkg for the res_t bundle.
module tlvts_out_stage (
  input  logic                                  clk,
  input  logic                                  rst,
  input  tlvts_pkg::res_t                       res,
  output logic                                  room,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [1:0]                            status,
  output logic [7:0]                            value_byte,
  output logic [tlvts_pkg::VALUE_LEN_W-1:0]     value_length,
  output logic                                  last
);
  import tlvts_pkg::*;

  assign room = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      status       <= res.status;
      value_byte   <= res.value_byte;
      value_length <= res.value_length;
      last         <= res.last;
    end
  end

endmodule

// File: rtl/tlv_path_tag_search.sv
// BER-TLV path and tag search: one request byte accepted per clock cycle.
// A byte accepted into the input register is parsed from there, and its result, if any,
// is then registered in the result register. Throughput: one byte per cycle, set by the
// parse step; the input stalls only while an untaken result fills the result register.
// Reset (rst, synchronous) empties both registers, restores the register defaults
// and makes the next byte start a new search.
module tlv_path_tag_search #(
  parameter int MAX_PATH_DEPTH = tlvts_pkg::MAX_PATH_DEPTH_DEF,
  parameter int LENGTH_BITS    = tlvts_pkg::LENGTH_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [tlvts_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlvts_pkg::CFG_DATA_W-1:0] cfg_data,
  tlvts_in_if.sink                         in_ch,
  tlvts_out_if.source                      out_ch
);
  import tlvts_pkg::*;

  cfg_t cfg;
  res_t res;
  logic room;

  tlvts_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  tlvts_parser #(
    .MAX_PATH_DEPTH (MAX_PATH_DEPTH),
    .LENGTH_BITS    (LENGTH_BITS)
  ) u_parser (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.data_byte),
    .in_sob   (in_ch.start_of_buffer),
    .out_room (room),
    .res      (res)
  );

  tlvts_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .res          (res),
    .room         (room),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .status       (out_ch.status),
    .value_byte   (out_ch.value_byte),
    .value_length (out_ch.value_length),
    .last         (out_ch.last)
  );

endmodule

// File: rtl/tlvts_checker.sv
// Port-level checker of the tag search result channel, bound to the top level.
// Depends on tlvts_pkg for status codes and on assert_macros.svh.
`include "assert_macros.svh"

module tlvts_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [7:0]  value_byte,
  input logic [23:0] value_length,
  input logic        last
);
  import tlvts_pkg::*;

  `TLVTS_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !out_valid, "result valid after reset")

  `TLVTS_ASSERT(a_stall_holds, clk, rst, out_valid && !out_ready |=> out_valid && $stable(status) && $stable(value_byte) && $stable(value_length) && $stable(last), "stalled result changed")

  `TLVTS_ASSERT(a_final_status, clk, rst, out_valid && status != ST_VALUE |-> last && value_byte == 8'h00 && value_length == 24'h0, "empty or error result malformed")

  `TLVTS_ASSERT(a_value_length, clk, rst, out_valid && status == ST_VALUE |-> value_length != 24'h0, "value byte with zero length")

endmodule

bind tlv_path_tag_search tlvts_checker u_tlvts_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .value_byte   (out_ch.value_byte),
  .value_length (out_ch.value_length),
  .last         (out_ch.last)
);
